FILE: design/mf3_pkg.sv
// Shared types, constants and compare-exchange helpers for the 3x3 median filter.
`default_nettype none

package mf3_pkg;

	localparam int PIX_W          = 8;
	localparam int FRAME_W_W      = 11;
	localparam int FRAME_H_W      = 13;
	localparam int ROW_W          = 12;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int HEIGHT_LIMIT   = 4096;
	localparam int WIDTH_RESET    = 640;
	localparam int HEIGHT_RESET   = 480;
	localparam int CFG_DATA_W     = 13;

	localparam logic CFG_FRAME_WIDTH  = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [8:0][PIX_W-1:0] win_t;

	function automatic win_t cmpx(win_t v, logic [3:0] i, logic [3:0] j);
		win_t r;
		r = v;
		if (v[i] > v[j]) begin
			r[i] = v[j];
			r[j] = v[i];
		end
		return r;
	endfunction

	// Sort each row of three.
	function automatic win_t sort_rows(win_t v);
		win_t r;
		r = v;
		r = cmpx(r, 4'd1, 4'd2);
		r = cmpx(r, 4'd4, 4'd5);
		r = cmpx(r, 4'd7, 4'd8);
		r = cmpx(r, 4'd0, 4'd1);
		r = cmpx(r, 4'd3, 4'd4);
		r = cmpx(r, 4'd6, 4'd7);
		r = cmpx(r, 4'd1, 4'd2);
		r = cmpx(r, 4'd4, 4'd5);
		r = cmpx(r, 4'd7, 4'd8);
		return r;
	endfunction

	// Merge the sorted rows column-wise.
	function automatic win_t merge_cols(win_t v);
		win_t r;
		r = v;
		r = cmpx(r, 4'd0, 4'd3);
		r = cmpx(r, 4'd5, 4'd8);
		r = cmpx(r, 4'd4, 4'd7);
		r = cmpx(r, 4'd3, 4'd6);
		r = cmpx(r, 4'd1, 4'd4);
		r = cmpx(r, 4'd2, 4'd5);
		return r;
	endfunction

	// Final compares that leave the median in entry four.
	function automatic pix_t pick_median(win_t v);
		win_t r;
		r = v;
		r = cmpx(r, 4'd4, 4'd7);
		r = cmpx(r, 4'd4, 4'd2);
		r = cmpx(r, 4'd6, 4'd4);
		r = cmpx(r, 4'd4, 4'd2);
		return r[4];
	endfunction

endpackage

`default_nettype wire

FILE: design/median_filter_3x3.sv
// Top level of the streaming 3x3 median filter with two line stores.
`default_nettype none

// Streaming 3x3 median filter for 8-bit grey pixels in raster order. One pixel
// is accepted per clock while the skid register is empty. A result passes the
// window, row sort, column merge and median registers to the output. The rate is
// set by the two line store memories, each read and written once per pixel on
// separate ports. Only interior pixels produce a result, and m_tlast marks the last
// one of a frame. A one-word skid register lets input continue while a result waits
// on the output. frame_width and frame_height are clamped to 3..MAX_WIDTH and 3..4096.
module median_filter_3x3
	import mf3_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,    // [7:0] pixel_in
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [7:0]                 m_tdata,    // [7:0] median_out
	output logic                       m_tlast,    // frame_done
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int CW  = (WW > FRAME_W_W) ? WW : FRAME_W_W;

	logic [FRAME_W_W-1:0] frame_width_q;
	logic [FRAME_H_W-1:0] frame_height_q;
	logic [CW-1:0]        col_q;
	logic [ROW_W-1:0]     row_q;

	logic [CW-1:0]        fw_ext;
	logic [CW-1:0]        weff;
	logic [FRAME_H_W-1:0] heff;
	logic                 col_wrap;
	logic [CW-1:0]        c0;
	logic [FRAME_H_W-1:0] r_inc;
	logic [FRAME_H_W-1:0] r0;
	logic                 emit0;
	logic                 last0;
	logic [CW-1:0]        c_inc;
	logic [CW-1:0]        col_next;
	logic [FRAME_H_W-1:0] r_step;
	logic [FRAME_H_W-1:0] row_next;

	logic                 en;
	logic                 accept;

	logic                 s1_valid;
	logic                 emit_s1;
	logic                 last_s1;
	logic [AW-1:0]        col_s1;
	pix_t                 px_s1;
	pix_t                 upper_rd_s1;
	pix_t                 lower_rd_s1;

	pix_t                 upper_mem [MAX_WIDTH];
	pix_t                 lower_mem [MAX_WIDTH];

	win_t                 window_q;
	logic                 s2_valid;
	logic                 last_s2;
	win_t                 sort_s3;
	logic                 s3_valid;
	logic                 last_s3;
	win_t                 sort_s4;
	logic                 s4_valid;
	logic                 last_s4;
	pix_t                 med_s5;
	logic                 s5_valid;
	logic                 last_s5;

	logic                 out_valid_q;
	pix_t                 out_med_q;
	logic                 out_last_q;
	logic                 skid_valid_q;
	pix_t                 skid_med_q;
	logic                 skid_last_q;
	logic                 take;

	assign cfg_ready = 1'b1;
	assign en        = !skid_valid_q;
	assign s_tready  = en;
	assign accept    = s_tvalid && en;
	assign take      = out_valid_q && m_tready;

	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_med_q;
	assign m_tlast   = out_last_q;

	always_comb begin
		fw_ext = CW'(frame_width_q);
		if (fw_ext < CW'(3)) begin
			weff = CW'(3);
		end else if (fw_ext > CW'(MAX_WIDTH)) begin
			weff = CW'(MAX_WIDTH);
		end else begin
			weff = fw_ext;
		end
		if (frame_height_q < FRAME_H_W'(3)) begin
			heff = FRAME_H_W'(3);
		end else if (frame_height_q > FRAME_H_W'(HEIGHT_LIMIT)) begin
			heff = FRAME_H_W'(HEIGHT_LIMIT);
		end else begin
			heff = frame_height_q;
		end
		col_wrap = (col_q >= weff);
		c0       = col_wrap ? '0 : col_q;
		r_inc    = FRAME_H_W'(row_q) + FRAME_H_W'(col_wrap);
		r0       = (r_inc >= heff) ? '0 : r_inc;
		emit0    = (r0 >= FRAME_H_W'(2)) && (c0 >= CW'(2));
		last0    = (r0 == heff - FRAME_H_W'(1)) && (c0 == weff - CW'(1));
		c_inc    = c0 + CW'(1);
		if (c_inc >= weff) begin
			col_next = '0;
			r_step   = r0 + FRAME_H_W'(1);
		end else begin
			col_next = c_inc;
			r_step   = r0;
		end
		row_next = (r_step >= heff) ? '0 : r_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_W_W'(WIDTH_RESET);
			frame_height_q <= FRAME_H_W'(HEIGHT_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FRAME_WIDTH: frame_width_q <= cfg_data[FRAME_W_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: frame_width_q <= frame_width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_next;
			row_q <= row_next[ROW_W-1:0];
		end
	end

	// Line stores: read on accept, written back from the stage-1 registers while the pipeline is enabled.
	always_ff @(posedge clk) begin
		if (en && s1_valid) begin
			upper_mem[col_s1] <= lower_rd_s1;
		end
		if (accept) begin
			upper_rd_s1 <= upper_mem[c0[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (en && s1_valid) begin
			lower_mem[col_s1] <= px_s1;
		end
		if (accept) begin
			lower_rd_s1 <= lower_mem[c0[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1  <= c0[AW-1:0];
			px_s1   <= s_tdata;
			emit_s1 <= emit0;
			last_s1 <= last0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
			s3_valid <= 1'b0;
			s4_valid <= 1'b0;
			s5_valid <= 1'b0;
			window_q <= '0;
		end else if (en) begin
			s1_valid <= accept;
			s2_valid <= s1_valid && emit_s1;
			s3_valid <= s2_valid;
			s4_valid <= s3_valid;
			s5_valid <= s4_valid;
			if (s1_valid) begin
				window_q[0] <= window_q[1];
				window_q[1] <= window_q[2];
				window_q[2] <= upper_rd_s1;
				window_q[3] <= window_q[4];
				window_q[4] <= window_q[5];
				window_q[5] <= lower_rd_s1;
				window_q[6] <= window_q[7];
				window_q[7] <= window_q[8];
				window_q[8] <= px_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s2 <= last_s1;
			sort_s3 <= sort_rows(window_q);
			last_s3 <= last_s2;
			sort_s4 <= merge_cols(sort_s3);
			last_s4 <= last_s3;
			med_s5  <= pick_median(sort_s4);
			last_s5 <= last_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (s5_valid) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_med_q  <= skid_med_q;
				out_last_q <= skid_last_q;
			end
		end else if (s5_valid) begin
			if (!out_valid_q || take) begin
				out_med_q  <= med_s5;
				out_last_q <= last_s5;
			end else begin
				skid_med_q  <= med_s5;
				skid_last_q <= last_s5;
			end
		end
	end

endmodule

`default_nettype wire
